### design/nmea_sentence_framer_core_macros.svh
// ----------------------------------------------------------------------------
// NMEA sentence framer assertion macros
// Concurrent assertion forms used by the framer parser.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH

// same-cycle implication
`define NSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/nsf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Character codes, address table and the words passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] HEX_NIBBLE_MASK = 8'h0F;

   localparam logic [7:0] MAX_LEN_RESET = 8'd100;

   localparam int          KNOWN_COUNT  = 6;
   localparam int          ADDR_CHARS   = 5;
   localparam logic [2:0]  TYPE_UNKNOWN = 3'd6;

   // entry 0 GPGGA ... entry 5 GPZDA, first character in the top byte
   localparam logic [KNOWN_COUNT-1:0][8*ADDR_CHARS-1:0] KNOWN_ADDR = {
      "GPZDA", "GPRMC", "GPRMB", "GPGSV", "GPGSA", "GPGGA"
   };

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_word_type;

   typedef struct packed {
      logic [2:0] sentence_type;
      logic [7:0] sentence_length;
      logic       had_checksum;
      logic [7:0] calc_checksum;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_word_type;

   function automatic logic [2:0] lookup_type(input logic                  five_chars,
                                              input logic [8*ADDR_CHARS-1:0] chars);
      logic [2:0] found;
      found = TYPE_UNKNOWN;
      for (int t = KNOWN_COUNT - 1; t >= 0; t--) begin
         if (five_chars && chars == KNOWN_ADDR[t]) begin
            found = 3'(t);
         end
      end
      return found;
   endfunction

endpackage

`default_nettype wire

### design/nsf_if.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer channels
// Byte request channel and sentence response channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] sentence_type;
   logic [7:0] sentence_length;
   logic       had_checksum;
   logic [7:0] calc_checksum;

   modport source (output valid, output sentence_type, output sentence_length,
                   output had_checksum, output calc_checksum, input ready);
   modport sink   (input valid, input sentence_type, input sentence_length,
                   input had_checksum, input calc_checksum, output ready);
endinterface

`default_nettype wire

### design/nsf_input_stage.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer input stage
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   nsf_req_if.sink               req_chan,
   input  logic                  advance,
   output nsf_pkg::byte_word_type in_word
);
   import nsf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_chan.rx_byte;
      end
   end

   assign in_word.valid = valid_ff;
   assign in_word.data  = data_ff;

endmodule

`default_nettype wire

### design/nsf_parser.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer parser
// Byte-wise framing state machine, checksum and address match.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_sentence_framer_core_macros.svh"

module nsf_parser #(
   parameter int ADDRESS_FIELD_LEN = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nsf_pkg::byte_word_type  in_word,
   input  logic                    advance,
   input  logic [7:0]              max_len,
   output nsf_pkg::result_word_type result_word
);
   import nsf_pkg::*;

   localparam int              CountW    = $clog2(ADDRESS_FIELD_LEN);
   localparam logic [CountW-1:0] AddrLimit = CountW'(ADDRESS_FIELD_LEN - 1);
   localparam logic [CountW-1:0] TypeChars = CountW'(ADDR_CHARS);

   typedef enum logic [6:0] {
      PH_SEARCH      = 7'b0000001,
      PH_ADDR        = 7'b0000010,
      PH_DATA        = 7'b0000100,
      PH_CK_HI       = 7'b0001000,
      PH_CK_LO       = 7'b0010000,
      PH_END_PLAIN   = 7'b0100000,
      PH_END_CHECKED = 7'b1000000
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [7:0]                 stored_ff, stored_in;
   logic [7:0]                 xor_ff, xor_in;
   logic                       high_ff, high_in;
   logic [3:0]                 hex_hi_ff, hex_hi_in;
   logic [CountW-1:0]          count_ff, count_in;
   logic [8*ADDR_CHARS-1:0]    chars_ff, chars_in;

   logic [7:0] c;
   logic [2:0] found_type;
   logic       finish, checked, over_len, c_is_hex;
   logic [3:0] c_hex;

   assign c        = in_word.data;
   assign over_len = stored_ff >= max_len;
   assign c_is_hex = (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
                     (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
   assign c_hex    = (c >= CHAR_UPPER_A) ? 4'(c & HEX_NIBBLE_MASK) + 4'd9
                                         : 4'(c & HEX_NIBBLE_MASK);
   assign found_type = lookup_type(count_ff == TypeChars, chars_ff);

   always_comb begin
      phase_in  = phase_ff;
      stored_in = stored_ff;
      xor_in    = xor_ff;
      high_in   = high_ff;
      hex_hi_in = hex_hi_ff;
      count_in  = count_ff;
      chars_in  = chars_ff;
      finish    = 1'b0;
      checked   = 1'b0;
      if (phase_ff != PH_SEARCH && over_len) begin
         phase_in = PH_SEARCH;
      end else begin
         case (phase_ff)
            PH_SEARCH: begin
               if (c == CHAR_DOLLAR) begin
                  stored_in = 8'd0;
                  xor_in    = 8'd0;
                  high_in   = 1'b0;
                  hex_hi_in = 4'd0;
                  count_in  = '0;
                  phase_in  = PH_ADDR;
               end
            end
            PH_ADDR: begin
               stored_in = stored_ff + 8'd1;
               xor_in    = xor_ff ^ c;
               if (c == CHAR_COMMA) begin
                  phase_in = PH_DATA;
               end else if (count_ff >= AddrLimit || c < CHAR_UPPER_A || c > CHAR_UPPER_Z) begin
                  phase_in = PH_SEARCH;
               end else begin
                  for (int i = 0; i < ADDR_CHARS; i++) begin
                     if (count_ff == CountW'(i)) begin
                        chars_in[8*(ADDR_CHARS-1-i) +: 8] = c;
                     end
                  end
                  count_in = count_ff + CountW'(1);
               end
            end
            PH_DATA: begin
               stored_in = stored_ff + 8'd1;
               if (c == CHAR_STAR) begin
                  phase_in = PH_CK_HI;
               end else if (c == CHAR_LF) begin
                  phase_in = PH_END_PLAIN;
               end else if (c == CHAR_CR) begin
                  finish   = 1'b1;
                  phase_in = PH_SEARCH;
               end else begin
                  xor_in = xor_ff ^ c;
                  if (c[7]) begin
                     high_in = 1'b1;
                  end
               end
            end
            PH_CK_HI: begin
               if (!c_is_hex) begin
                  phase_in = PH_SEARCH;
               end else begin
                  stored_in = stored_ff + 8'd1;
                  hex_hi_in = c_hex;
                  phase_in  = PH_CK_LO;
               end
            end
            PH_CK_LO: begin
               if (!c_is_hex) begin
                  phase_in = PH_SEARCH;
               end else begin
                  stored_in = stored_ff + 8'd1;
                  if (!high_ff && {hex_hi_ff, c_hex} == xor_ff) begin
                     phase_in = PH_END_CHECKED;
                  end else begin
                     phase_in = PH_SEARCH;
                  end
               end
            end
            PH_END_PLAIN, PH_END_CHECKED: begin
               if (c == CHAR_CR) begin
                  stored_in = stored_ff + 8'd1;
                  finish    = 1'b1;
                  checked   = (phase_ff == PH_END_CHECKED);
                  phase_in  = PH_SEARCH;
               end else if (c != CHAR_LF) begin
                  phase_in = PH_SEARCH;
               end
            end
            default: begin
               phase_in = PH_SEARCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         stored_ff <= 8'd0;
         xor_ff    <= 8'd0;
         high_ff   <= 1'b0;
         hex_hi_ff <= 4'd0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         stored_ff <= stored_in;
         xor_ff    <= xor_in;
         high_ff   <= high_in;
         hex_hi_ff <= hex_hi_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chars_ff <= chars_in;
      end
   end

   assign result_word.valid                   = finish && found_type != TYPE_UNKNOWN;
   assign result_word.payload.sentence_type   = found_type;
   assign result_word.payload.sentence_length = stored_in;
   assign result_word.payload.had_checksum    = checked;
   assign result_word.payload.calc_checksum   = xor_ff;

   `NSF_ASSERT_NEXT(a_emit_restarts, clock, reset, advance && result_word.valid, phase_ff == PH_SEARCH, "parser not back in search after a sentence")
   `NSF_ASSERT_NOW(a_emit_five_chars, clock, reset, result_word.valid, count_ff == TypeChars, "sentence emitted without a five character address")
   `NSF_ASSERT_NOW(a_checked_clean, clock, reset, result_word.valid && result_word.payload.had_checksum, !high_ff, "verified checksum with a high byte seen")
   `NSF_ASSERT_NOW(a_addr_bound, clock, reset, 1'b1, count_ff <= AddrLimit, "address count beyond the field limit")

endmodule

`default_nettype wire

### design/nsf_output_stage.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer output stage
// Result register in front of the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_output_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  nsf_pkg::result_word_type result_word,
   output logic                     out_free,
   nsf_rsp_if.source                rsp_chan
);
   import nsf_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result_word.valid;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_word.valid) begin
         payload_ff <= result_word.payload;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.sentence_type   = payload_ff.sentence_type;
   assign rsp_chan.sentence_length = payload_ff.sentence_length;
   assign rsp_chan.had_checksum    = payload_ff.had_checksum;
   assign rsp_chan.calc_checksum   = payload_ff.calc_checksum;

endmodule

`default_nettype wire

### design/nmea_sentence_framer_core.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer core
// Frames NMEA 0183 sentences from a byte stream and reports known types.
//
//   channel   dir  word                               handshake
//   req_chan  in   rx_byte                            valid/ready
//   rsp_chan  out  type, length, checksum flag, xor   valid/ready
//   csr_*     in   max_sentence_length                write enable
//
// One byte a cycle unless responses stall; input and output are registered.
// The rate is set by the single parser state update on each byte.
// A byte that ends a known sentence yields one response word, others none.
// A stalled response only holds the parser once its register and the
// input register are both full.
// Synchronous reset; length limit resets to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer_core #(
   parameter int ADDRESS_FIELD_LEN = 10
) (
   input  logic       clock,
   input  logic       reset,
   nsf_req_if.sink    req_chan,
   nsf_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import nsf_pkg::*;

   logic [7:0]      max_len_ff;
   byte_word_type   in_word;
   result_word_type result_word;
   logic            out_free;
   logic            advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign advance = in_word.valid && out_free;

   nsf_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_word  (in_word)
   );

   nsf_parser #(
      .ADDRESS_FIELD_LEN (ADDRESS_FIELD_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_word     (in_word),
      .advance     (advance),
      .max_len     (max_len_ff),
      .result_word (result_word)
   );

   nsf_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .result_word (result_word),
      .out_free    (out_free),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence framer core testbench
// Streams well-formed, damaged and noisy NMEA sentences into the framer
// under several length limits and random back-pressure on both channels.
// A scoreboard tracks the framing state byte by byte and checks every
// sentence word against its own prediction.
// ----------------------------------------------------------------------------

module tb_top;
   import nsf_pkg::*;

   localparam int ADDR_FIELD_LEN = 10;
   localparam int CLOCK_PERIOD   = 20;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_BYTES    = 190;

   class sentence_scoreboard;
      typedef enum logic [2:0] {
         PH_HUNT, PH_ADDRESS, PH_BODY, PH_SUM_HI, PH_SUM_LO, PH_TAIL_PLAIN, PH_TAIL_CHECKED
      } frame_phase_type;

      logic [7:0]      max_len;
      frame_phase_type phase;
      logic [7:0]      stored_count;
      logic [7:0]      running_xor;
      logic            high_seen;
      logic [3:0]      sum_hi;
      logic [7:0]      addr_chars [ADDR_FIELD_LEN-1];
      logic [3:0]      addr_count;
      rsp_payload_type expected_q [$];
      int              mismatches;

      function new();
         max_len      = MAX_LEN_RESET;
         phase        = PH_HUNT;
         stored_count = '0;
         running_xor  = '0;
         high_seen    = 1'b0;
         sum_hi       = '0;
         addr_count   = '0;
         mismatches   = 0;
      endfunction

      function bit is_hex(input logic [7:0] c);
         return (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
                (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
      endfunction

      function logic [3:0] hex_value(input logic [7:0] c);
         logic [7:0] v;
         v = c & HEX_NIBBLE_MASK;
         if (c >= CHAR_UPPER_A) v = v + 8'd9;
         return v[3:0];
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task close_sentence(input bit checked);
         logic [8*ADDR_CHARS-1:0] chars;
         logic [2:0]              found;
         rsp_payload_type         w;
         found = TYPE_UNKNOWN;
         phase = PH_HUNT;
         if (addr_count == ADDR_CHARS) begin
            for (int i = 0; i < ADDR_CHARS; i++) chars[8*(ADDR_CHARS-1-i) +: 8] = addr_chars[i];
            for (int t = 0; t < KNOWN_COUNT; t++) begin
               if (chars == KNOWN_ADDR[t]) found = 3'(t);
            end
         end
         if (found != TYPE_UNKNOWN) begin
            w.sentence_type   = found;
            w.sentence_length = stored_count;
            w.had_checksum    = checked;
            w.calc_checksum   = running_xor;
            expected_q.push_back(w);
         end
      endtask

      task note_byte(input logic [7:0] c);
         if (phase == PH_HUNT) begin
            if (c == CHAR_DOLLAR) begin
               addr_count   = '0;
               stored_count = '0;
               running_xor  = '0;
               high_seen    = 1'b0;
               sum_hi       = '0;
               phase        = PH_ADDRESS;
            end
         end else if (stored_count >= max_len) begin
            phase = PH_HUNT;
         end else begin
            case (phase)
               PH_ADDRESS: begin
                  stored_count++;
                  running_xor ^= c;
                  if (c == CHAR_COMMA) begin
                     phase = PH_BODY;
                  end else if (addr_count >= ADDR_FIELD_LEN - 1 || c < CHAR_UPPER_A ||
                               c > CHAR_UPPER_Z) begin
                     phase = PH_HUNT;
                  end else begin
                     addr_chars[addr_count] = c;
                     addr_count++;
                  end
               end
               PH_BODY: begin
                  stored_count++;
                  if (c == CHAR_STAR) begin
                     phase = PH_SUM_HI;
                  end else if (c == CHAR_LF) begin
                     phase = PH_TAIL_PLAIN;
                  end else if (c == CHAR_CR) begin
                     close_sentence(1'b0);
                  end else begin
                     running_xor ^= c;
                     if (c[7]) high_seen = 1'b1;
                  end
               end
               PH_SUM_HI: begin
                  if (!is_hex(c)) begin
                     phase = PH_HUNT;
                  end else begin
                     stored_count++;
                     sum_hi = hex_value(c);
                     phase  = PH_SUM_LO;
                  end
               end
               PH_SUM_LO: begin
                  if (!is_hex(c)) begin
                     phase = PH_HUNT;
                  end else begin
                     stored_count++;
                     if (!high_seen && {sum_hi, hex_value(c)} == running_xor)
                        phase = PH_TAIL_CHECKED;
                     else
                        phase = PH_HUNT;
                  end
               end
               default: begin
                  if (c == CHAR_CR) begin
                     stored_count++;
                     close_sentence(phase == PH_TAIL_CHECKED);
                  end else if (c != CHAR_LF) begin
                     phase = PH_HUNT;
                  end
               end
            endcase
         end
      endtask

      task check_word(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word type %0d length %0d xor %02h",
                                      got.sentence_type, got.sentence_length,
                                      got.calc_checksum));
         end else begin
            want = expected_q.pop_front();
            if (got.sentence_type !== want.sentence_type)
               report_mismatch($sformatf("sentence_type %0d, want %0d",
                                         got.sentence_type, want.sentence_type));
            if (got.sentence_length !== want.sentence_length)
               report_mismatch($sformatf("sentence_length %0d, want %0d",
                                         got.sentence_length, want.sentence_length));
            if (got.had_checksum !== want.had_checksum)
               report_mismatch($sformatf("had_checksum %0d, want %0d",
                                         got.had_checksum, want.had_checksum));
            if (got.calc_checksum !== want.calc_checksum)
               report_mismatch($sformatf("calc_checksum %02h, want %02h",
                                         got.calc_checksum, want.calc_checksum));
         end
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         cycle_count = 0;
   logic [7:0] frame_q [$];

   sentence_scoreboard sb;

   nsf_req_if req_chan ();
   nsf_rsp_if rsp_chan ();

   nmea_sentence_framer_core #(
      .ADDRESS_FIELD_LEN (ADDR_FIELD_LEN)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : sentence_monitor
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.sentence_type   = rsp_chan.sentence_type;
         got.sentence_length = rsp_chan.sentence_length;
         got.had_checksum    = rsp_chan.had_checksum;
         got.calc_checksum   = rsp_chan.calc_checksum;
         sb.check_word(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[nmea_sentence_framer_core] ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.max_len   = value;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) return CHAR_DIGIT_0 + 8'(nibble);
      return CHAR_UPPER_A + 8'(nibble) - 8'd10;
   endfunction

   function automatic logic [7:0] random_letter();
      return CHAR_UPPER_A + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] random_body_byte();
      int         p;
      logic [7:0] b;
      p = $urandom_range(99);
      if (p < 6) return 8'($urandom_range(255, 128));
      if (p < 9) return 8'($urandom_range(255));
      b = 8'($urandom_range(8'h7E, 8'h20));
      if (b == CHAR_STAR) b = CHAR_COMMA;
      return b;
   endfunction

   function automatic void add_known(input int t);
      for (int i = 0; i < ADDR_CHARS; i++)
         frame_q.push_back(KNOWN_ADDR[t][8*(ADDR_CHARS-1-i) +: 8]);
   endfunction

   // checksum digits over everything after the '$'
   function automatic void add_sum(input bit corrupt);
      logic [7:0] sum;
      sum = '0;
      for (int i = 1; i < frame_q.size(); i++) sum ^= frame_q[i];
      if (corrupt) sum ^= 8'($urandom_range(255, 1));
      frame_q.push_back(CHAR_STAR);
      frame_q.push_back(hex_char(sum[7:4]));
      frame_q.push_back(hex_char(sum[3:0]));
   endfunction

   function automatic void build_random_frame();
      int pick;
      int n;
      frame_q.delete();
      frame_q.push_back(CHAR_DOLLAR);
      pick = $urandom_range(99);
      if (pick < 78) begin
         add_known($urandom_range(KNOWN_COUNT - 1));
         if (pick >= 70) frame_q[$urandom_range(ADDR_CHARS, 1)] = random_letter();
      end else if (pick < 92) begin
         repeat ($urandom_range(11)) frame_q.push_back(random_letter());
      end else begin
         add_known($urandom_range(KNOWN_COUNT - 1));
         frame_q[$urandom_range(ADDR_CHARS, 1)] = 8'($urandom_range(255));
      end
      frame_q.push_back(CHAR_COMMA);
      n = ($urandom_range(99) < 5) ? $urandom_range(240, 100) : $urandom_range(24);
      repeat (n) frame_q.push_back(random_body_byte());
      if ($urandom_range(99) < 55) begin
         add_sum($urandom_range(99) < 10);
         if ($urandom_range(99) < 5)
            frame_q[frame_q.size() - 1 - $urandom_range(1)] = 8'($urandom_range(255));
      end
      n = ($urandom_range(99) < 15) ? $urandom_range(2, 1) : 0;
      repeat (n) frame_q.push_back(CHAR_LF);
      frame_q.push_back(($urandom_range(99) < 92) ? CHAR_CR : 8'($urandom_range(255)));
      if ($urandom_range(1)) frame_q.push_back(CHAR_LF);
   endfunction

   task automatic run_phase(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end
         build_random_frame();
         send_frame();
         sent += frame_q.size();
      end
   endtask

   initial begin
      sb               = new();
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      reset            = 1'b1;
      send_idle_pct    = 24;
      recv_idle_pct    = 56;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // checked sentence with LF before CR, then one spoilt by a high byte
      frame_q.delete();
      frame_q.push_back(CHAR_DOLLAR);
      add_known(5);
      frame_q.push_back(CHAR_COMMA);
      frame_q.push_back(CHAR_DIGIT_0 + 8'd1);
      add_sum(1'b0);
      frame_q.push_back(CHAR_LF);
      frame_q.push_back(CHAR_CR);
      send_frame();
      frame_q.delete();
      frame_q.push_back(CHAR_DOLLAR);
      add_known(4);
      frame_q.push_back(CHAR_COMMA);
      frame_q.push_back(8'hFF);
      add_sum(1'b0);
      frame_q.push_back(CHAR_CR);
      send_frame();

      run_phase(PHASE_BYTES);
      write_limit(8'd255);
      run_phase(PHASE_BYTES);
      write_limit(8'd8);
      run_phase(PHASE_BYTES);

      send_idle_pct = 56;
      recv_idle_pct = 24;
      write_limit(8'd0);
      run_phase(PHASE_BYTES);
      write_limit(8'($urandom_range(255, 8)));
      run_phase(PHASE_BYTES);
      write_limit(8'd255);
      run_phase(PHASE_BYTES);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(8'd9);
      run_phase(PHASE_BYTES);
      write_limit(MAX_LEN_RESET);
      run_phase(PHASE_BYTES);
      write_limit(8'($urandom_range(255, 8)));
      run_phase(PHASE_BYTES);

      quiesce();
      if (sb.mismatches == 0) begin
         $display("[nmea_sentence_framer_core] OK");
      end else begin
         $display("[nmea_sentence_framer_core] ERROR");
      end
      $finish;
   end

endmodule
